// ----- rtl/core/aiou_pkg.sv -----
package aiou_pkg;

   localparam int AXES       = 3;
   localparam int COORD_W    = 16;
   localparam int FIELDS     = 4 * AXES;
   localparam int REQ_W      = FIELDS * COORD_W;
   localparam int PROD_W     = 2 * COORD_W;
   localparam int VOL_W      = 3 * COORD_W;
   localparam int UNI_W      = VOL_W + 1;
   localparam int IOU_W      = 17;
   localparam int DIV_STAGES = IOU_W;
   localparam int RES_W      = IOU_W + 2;
   localparam int RSP_W      = ((RES_W + 7) / 8) * 8;
   localparam int FIFO_DEPTH = 32;
   localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
   localparam int CREDIT_W   = $clog2(FIFO_DEPTH + 1);

   // field slots inside req_tdata
   localparam int A_CENTER = 0;
   localparam int A_SIZE   = AXES;
   localparam int B_CENTER = 2 * AXES;
   localparam int B_SIZE   = 3 * AXES;

   typedef struct packed {
      logic                            strict;
      logic                            both_valid;
      logic [AXES-1:0][COORD_W-1:0]    ov;
      logic [AXES-1:0][COORD_W-1:0]    sa;
      logic [AXES-1:0][COORD_W-1:0]    sb;
   } ovl_type;

   typedef struct packed {
      logic               strict;
      logic               both_valid;
      logic [VOL_W-1:0]   inter;
      logic [UNI_W-1:0]   uni;
   } vol_type;

   typedef struct packed {
      logic               both_valid;
      logic               overlap;
      logic [IOU_W-1:0]   iou;
   } result_type;

endpackage

// ----- rtl/core/aiou_overlap.sv -----
module aiou_overlap (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   input  logic [aiou_pkg::REQ_W-1:0]  in_data,
   output logic                        out_valid,
   output aiou_pkg::ovl_type           out_ovl
);

   logic [aiou_pkg::AXES-1:0][aiou_pkg::COORD_W-1:0] ac, as, bc, bs;
   logic [aiou_pkg::AXES-1:0][aiou_pkg::COORD_W+1:0] alo, ahi, blo, bhi, lo, hi;
   logic [aiou_pkg::AXES-1:0][aiou_pkg::COORD_W+2:0] dif;
   logic [aiou_pkg::AXES-1:0]                        ax_pos, a_pos, b_pos;
   aiou_pkg::ovl_type                                ovl_in, ovl_ff;
   logic                                             valid_ff;

   always_comb begin
      ovl_in = '0;
      for (int k = 0; k < aiou_pkg::AXES; k++) begin
         ac[k] = in_data[aiou_pkg::COORD_W*(aiou_pkg::A_CENTER+k) +: aiou_pkg::COORD_W];
         as[k] = in_data[aiou_pkg::COORD_W*(aiou_pkg::A_SIZE+k)   +: aiou_pkg::COORD_W];
         bc[k] = in_data[aiou_pkg::COORD_W*(aiou_pkg::B_CENTER+k) +: aiou_pkg::COORD_W];
         bs[k] = in_data[aiou_pkg::COORD_W*(aiou_pkg::B_SIZE+k)   +: aiou_pkg::COORD_W];
         alo[k] = {ac[k][aiou_pkg::COORD_W-1], ac[k], 1'b0}
                - {{2{as[k][aiou_pkg::COORD_W-1]}}, as[k]};
         ahi[k] = {ac[k][aiou_pkg::COORD_W-1], ac[k], 1'b0}
                + {{2{as[k][aiou_pkg::COORD_W-1]}}, as[k]};
         blo[k] = {bc[k][aiou_pkg::COORD_W-1], bc[k], 1'b0}
                - {{2{bs[k][aiou_pkg::COORD_W-1]}}, bs[k]};
         bhi[k] = {bc[k][aiou_pkg::COORD_W-1], bc[k], 1'b0}
                + {{2{bs[k][aiou_pkg::COORD_W-1]}}, bs[k]};
         lo[k] = ($signed(alo[k]) > $signed(blo[k])) ? alo[k] : blo[k];
         hi[k] = ($signed(ahi[k]) < $signed(bhi[k])) ? ahi[k] : bhi[k];
         dif[k] = {hi[k][aiou_pkg::COORD_W+1], hi[k]} - {lo[k][aiou_pkg::COORD_W+1], lo[k]};
         ax_pos[k] = !dif[k][aiou_pkg::COORD_W+2] && (dif[k] != '0);
         a_pos[k]  = !as[k][aiou_pkg::COORD_W-1] && (as[k] != '0);
         b_pos[k]  = !bs[k][aiou_pkg::COORD_W-1] && (bs[k] != '0);
         // clamp non-positive overlap at zero
         ovl_in.ov[k] = ax_pos[k] ? dif[k][aiou_pkg::COORD_W-1:0] : '0;
         ovl_in.sa[k] = {as[k][aiou_pkg::COORD_W-2:0], 1'b0};
         ovl_in.sb[k] = {bs[k][aiou_pkg::COORD_W-2:0], 1'b0};
      end
      ovl_in.both_valid = (&a_pos) & (&b_pos);
      ovl_in.strict     = ovl_in.both_valid & (&ax_pos);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      ovl_ff <= ovl_in;
   end

   assign out_valid = valid_ff;
   assign out_ovl   = ovl_ff;

endmodule

// ----- rtl/core/aiou_volume.sv -----
module aiou_volume (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  aiou_pkg::ovl_type   in_ovl,
   output logic                out_valid,
   output aiou_pkg::vol_type   out_vol
);

   typedef struct packed {
      logic                             strict;
      logic                             both_valid;
      logic [aiou_pkg::PROD_W-1:0]      pov;
      logic [aiou_pkg::PROD_W-1:0]      pa;
      logic [aiou_pkg::PROD_W-1:0]      pb;
      logic [aiou_pkg::COORD_W-1:0]     ovz;
      logic [aiou_pkg::COORD_W-1:0]     saz;
      logic [aiou_pkg::COORD_W-1:0]     sbz;
   } prod_type;

   typedef struct packed {
      logic                         strict;
      logic                         both_valid;
      logic [aiou_pkg::VOL_W-1:0]   inter;
      logic [aiou_pkg::VOL_W-1:0]   va;
      logic [aiou_pkg::VOL_W-1:0]   vb;
   } cube_type;

   prod_type            prod_in, prod_ff;
   cube_type            cube_in, cube_ff;
   aiou_pkg::vol_type   vol_in, vol_ff;
   logic [2:0]          valid_ff;

   always_comb begin
      prod_in.strict     = in_ovl.strict;
      prod_in.both_valid = in_ovl.both_valid;
      prod_in.pov = aiou_pkg::PROD_W'(in_ovl.ov[0]) * aiou_pkg::PROD_W'(in_ovl.ov[1]);
      prod_in.pa  = aiou_pkg::PROD_W'(in_ovl.sa[0]) * aiou_pkg::PROD_W'(in_ovl.sa[1]);
      prod_in.pb  = aiou_pkg::PROD_W'(in_ovl.sb[0]) * aiou_pkg::PROD_W'(in_ovl.sb[1]);
      prod_in.ovz = in_ovl.ov[2];
      prod_in.saz = in_ovl.sa[2];
      prod_in.sbz = in_ovl.sb[2];
   end

   always_comb begin
      cube_in.strict     = prod_ff.strict;
      cube_in.both_valid = prod_ff.both_valid;
      cube_in.inter = aiou_pkg::VOL_W'(prod_ff.pov) * aiou_pkg::VOL_W'(prod_ff.ovz);
      cube_in.va    = aiou_pkg::VOL_W'(prod_ff.pa)  * aiou_pkg::VOL_W'(prod_ff.saz);
      cube_in.vb    = aiou_pkg::VOL_W'(prod_ff.pb)  * aiou_pkg::VOL_W'(prod_ff.sbz);
   end

   always_comb begin
      vol_in.strict     = cube_ff.strict;
      vol_in.both_valid = cube_ff.both_valid;
      vol_in.inter      = cube_ff.inter;
      vol_in.uni        = aiou_pkg::UNI_W'(cube_ff.va) + aiou_pkg::UNI_W'(cube_ff.vb)
                        - aiou_pkg::UNI_W'(cube_ff.inter);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      cube_ff <= cube_in;
      vol_ff  <= vol_in;
   end

   assign out_valid = valid_ff[2];
   assign out_vol   = vol_ff;

endmodule

// ----- rtl/core/aiou_divider.sv -----
module aiou_divider (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   input  aiou_pkg::vol_type      in_vol,
   output logic                   out_valid,
   output aiou_pkg::result_type   out_res
);

   typedef struct packed {
      logic                         strict;
      logic                         both_valid;
      logic [aiou_pkg::UNI_W-1:0]   rem;
      logic [aiou_pkg::UNI_W-1:0]   uni;
      logic [aiou_pkg::IOU_W-1:0]   quo;
   } div_type;

   logic    [aiou_pkg::DIV_STAGES-1:0] valid_ff;
   div_type [aiou_pkg::DIV_STAGES-1:0] div_ff;
   div_type [aiou_pkg::DIV_STAGES-1:0] div_in;

   for (genvar s = 0; s < aiou_pkg::DIV_STAGES; s++) begin : g_stage
      div_type                    cur;
      logic                       cur_valid;
      logic [aiou_pkg::UNI_W:0]   trial;
      logic [aiou_pkg::UNI_W:0]   diff;

      if (s == 0) begin : g_first
         assign cur = {in_vol.strict, in_vol.both_valid, aiou_pkg::UNI_W'(in_vol.inter),
                       in_vol.uni, {aiou_pkg::IOU_W{1'b0}}};
         assign cur_valid = in_valid;
         assign trial = {1'b0, cur.rem};
      end else begin : g_next
         assign cur = div_ff[s-1];
         assign cur_valid = valid_ff[s-1];
         // shift remainder for the next quotient bit
         assign trial = {cur.rem, 1'b0};
      end

      always_comb begin
         div_in[s] = cur;
         diff = trial - {1'b0, cur.uni};
         if (!diff[aiou_pkg::UNI_W]) begin
            div_in[s].rem = diff[aiou_pkg::UNI_W-1:0];
            div_in[s].quo[aiou_pkg::DIV_STAGES-1-s] = 1'b1;
         end else begin
            div_in[s].rem = trial[aiou_pkg::UNI_W-1:0];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else begin
            valid_ff[s] <= cur_valid;
         end
      end

      always_ff @(posedge clock) begin
         div_ff[s] <= div_in[s];
      end
   end

   always_comb begin
      out_res.both_valid = div_ff[aiou_pkg::DIV_STAGES-1].both_valid;
      out_res.overlap    = div_ff[aiou_pkg::DIV_STAGES-1].strict;
      out_res.iou        = div_ff[aiou_pkg::DIV_STAGES-1].both_valid
                         ? div_ff[aiou_pkg::DIV_STAGES-1].quo : '0;
   end

   assign out_valid = valid_ff[aiou_pkg::DIV_STAGES-1];

endmodule

// ----- rtl/core/aiou_rsp_buffer.sv -----
module aiou_rsp_buffer (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_accept,
   input  logic                   in_valid,
   input  aiou_pkg::result_type   in_res,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output aiou_pkg::result_type   rsp_res
);

   aiou_pkg::result_type            mem_ff [aiou_pkg::FIFO_DEPTH];
   aiou_pkg::result_type            out_ff;
   logic                            out_valid_ff, out_valid_in;
   logic [aiou_pkg::FIFO_AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [aiou_pkg::FIFO_AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [aiou_pkg::CREDIT_W-1:0]   fill_ff, fill_in;
   logic [aiou_pkg::CREDIT_W-1:0]   credit_ff, credit_in;
   logic                            pop;
   logic                            load;
   logic                            mem_empty;
   logic                            mem_wr;
   logic                            mem_rd;

   assign mem_empty = (fill_ff == '0);
   assign rsp_valid = out_valid_ff;
   assign pop       = out_valid_ff && rsp_ready;
   assign load      = !out_valid_ff || pop;
   // refill the output register from the buffer, or straight from the pipeline when empty
   assign mem_rd    = load && !mem_empty;
   assign mem_wr    = in_valid && !(load && mem_empty);
   assign rsp_res   = out_ff;
   // hold back requests once every buffer slot is spoken for
   assign req_ready = (credit_ff != aiou_pkg::CREDIT_W'(aiou_pkg::FIFO_DEPTH));

   always_comb begin
      wr_ptr_in    = wr_ptr_ff + aiou_pkg::FIFO_AW'(mem_wr);
      rd_ptr_in    = rd_ptr_ff + aiou_pkg::FIFO_AW'(mem_rd);
      fill_in      = fill_ff + aiou_pkg::CREDIT_W'(mem_wr) - aiou_pkg::CREDIT_W'(mem_rd);
      credit_in    = credit_ff + aiou_pkg::CREDIT_W'(req_accept) - aiou_pkg::CREDIT_W'(pop);
      out_valid_in = load ? (!mem_empty || in_valid) : 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff    <= '0;
         rd_ptr_ff    <= '0;
         fill_ff      <= '0;
         credit_ff    <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         wr_ptr_ff    <= wr_ptr_in;
         rd_ptr_ff    <= rd_ptr_in;
         fill_ff      <= fill_in;
         credit_ff    <= credit_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_wr) begin
         mem_ff[wr_ptr_ff] <= in_res;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_rd) begin
         out_ff <= mem_ff[rd_ptr_ff];
      end else if (load && in_valid) begin
         out_ff <= in_res;
      end
   end

endmodule

// ----- rtl/core/aabb_iou_unit.sv -----
// channel  direction  handshake              payload
// req      in         req_tvalid/req_tready  req_tdata: two boxes, twelve signed Q8.8 words
// rsp      out        rsp_tvalid/rsp_tready  rsp_tdata: iou, overlap, both_valid
//
// Takes one request per cycle while req_tready is high; each result passes through
// the four arithmetic stages, the 17-stage restoring divider and the output register.
// The pipeline never stops; a 32-entry result buffer absorbs back-pressure and
// req_tready drops while 32 requests are outstanding.
// Synchronous reset clears the valid bits, buffer pointers and request count.
module aabb_iou_unit (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   // a_center_x, a_center_y, a_center_z, a_size_x, a_size_y, a_size_z,
   // b_center_x, b_center_y, b_center_z, b_size_x, b_size_y, b_size_z (16 bits each)
   input  logic [aiou_pkg::REQ_W-1:0]  req_tdata,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   // iou [16:0], overlap [17], both_valid [18], zero [23:19]
   output logic [aiou_pkg::RSP_W-1:0]  rsp_tdata
);

   logic                   req_accept;
   logic                   ovl_valid;
   aiou_pkg::ovl_type      ovl;
   logic                   vol_valid;
   aiou_pkg::vol_type      vol;
   logic                   res_valid;
   aiou_pkg::result_type   res;
   aiou_pkg::result_type   rsp_res;

   assign req_accept = req_tvalid && req_tready;

   aiou_overlap u_overlap (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_accept),
      .in_data   (req_tdata),
      .out_valid (ovl_valid),
      .out_ovl   (ovl)
   );

   aiou_volume u_volume (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (ovl_valid),
      .in_ovl    (ovl),
      .out_valid (vol_valid),
      .out_vol   (vol)
   );

   aiou_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (vol_valid),
      .in_vol    (vol),
      .out_valid (res_valid),
      .out_res   (res)
   );

   aiou_rsp_buffer u_rsp_buffer (
      .clock      (clock),
      .reset      (reset),
      .req_accept (req_accept),
      .in_valid   (res_valid),
      .in_res     (res),
      .req_ready  (req_tready),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_res    (rsp_res)
   );

   assign rsp_tdata = aiou_pkg::RSP_W'(rsp_res);

endmodule

// ----- rtl/core/aiou_checker.sv -----
module aiou_checker (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   input  logic [aiou_pkg::RSP_W-1:0]  rsp_tdata
);

   logic [aiou_pkg::IOU_W-1:0] iou;
   logic                       overlap;
   logic                       both_valid;

   assign iou        = rsp_tdata[aiou_pkg::IOU_W-1:0];
   assign overlap    = rsp_tdata[aiou_pkg::IOU_W];
   assign both_valid = rsp_tdata[aiou_pkg::IOU_W+1];

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");

   a_overlap_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && overlap |-> both_valid)
      else $error("overlap without both boxes valid");

   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !both_valid |-> iou == '0 && !overlap)
      else $error("invalid pair gave nonzero iou or overlap");

   a_iou_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> iou <= aiou_pkg::IOU_W'(65536))
      else $error("iou above one");

endmodule

bind aabb_iou_unit aiou_checker u_aiou_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
